### sv/rsb_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit send buffer package
// Shared constants, codes and types of the retransmit send buffer.
// ----------------------------------------------------------------------------
package rsb_pkg;

   localparam int DEPTH       = 64;
   localparam int HANDLE_BITS = 16;
   localparam int PTR_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);

   localparam logic [31:0] HALF_SPAN = 32'h8000_0000;
   localparam logic [31:0] ALL32     = 32'hffff_ffff;

   // Input action codes
   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_DROP  = 2'd1;
   localparam logic [1:0] ACT_RANGE = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_PUSHED   = 3'd0;
   localparam logic [2:0] ST_DROP_OK  = 3'd1;
   localparam logic [2:0] ST_REFUSED  = 3'd2;
   localparam logic [2:0] ST_ENTRY    = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] REG_LATENCY = 2'd0;
   localparam logic [1:0] REG_LATE    = 2'd1;
   localparam logic [1:0] REG_TSBPD   = 2'd2;

   // One held record
   typedef struct packed {
      logic [31:0]            seq;
      logic [31:0]            tstamp;
      logic [HANDLE_BITS-1:0] hnd;
   } rec_type;

   // Controller to ring: shift and load commands
   typedef struct packed {
      logic    shift;    // every cell takes its neighbour's record
      logic    load;     // write tail cell
      logic [PTR_BITS-1:0] load_pos;
      rec_type load_rec;
   } ring_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LATE,
      S_DROP,
      S_RANGE,
      S_OUT
   } state_type;

endpackage

### sv/rsb_cell.sv
// ----------------------------------------------------------------------------
// Retransmit send buffer cell
// One record slot of the ring; takes its neighbour's record on a shift.
// ----------------------------------------------------------------------------
module rsb_cell
   import rsb_pkg::*;
(
   input  logic    clock,
   input  logic    shift,
   input  logic    load,
   input  rec_type load_rec,
   input  rec_type next_rec,
   output rec_type rec
);

   rec_type rec_ff;
   rec_type rec_in;

   // Load wins over shift; loads happen at the tail after any rotation.
   always_comb begin
      rec_in = rec_ff;
      if (load) begin
         rec_in = load_rec;
      end else if (shift) begin
         rec_in = next_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

### sv/rsb_ring.sv
// ----------------------------------------------------------------------------
// Retransmit send buffer ring
// Chain of record cells; cell 0 holds the oldest record whenever the buffer is idle.
// ----------------------------------------------------------------------------
module rsb_ring
   import rsb_pkg::*;
(
   input  logic         clock,
   input  ring_ctl_type ctl,
   output rec_type      head_rec
);

   rec_type cell_q [DEPTH];

   // Each cell hands its record towards the head; the last wraps round.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      rsb_cell u_cell (
         .clock    (clock),
         .shift    (ctl.shift),
         .load     (ctl.load && (ctl.load_pos == PTR_BITS'(g))),
         .load_rec (ctl.load_rec),
         .next_rec (cell_q[(g + 1) % DEPTH]),
         .rec      (cell_q[g])
      );
   end

   assign head_rec = cell_q[0];

endmodule

### sv/retransmit_send_buffer.sv
// ----------------------------------------------------------------------------
// Retransmit send buffer
// Ring of sent-packet records with latency drop, acknowledge drop and lookup.
// ----------------------------------------------------------------------------
// The records sit in a chain of 64 cells with the oldest in cell 0 whenever
// the buffer is idle; popping is a rotation of the whole chain. A push loads
// the record at the tail, then pops the oldest while the span is too wide. An
// acknowledge drop rotates past the records before the target; a target that
// is not held costs a full turn of the chain to put it back. A range lookup
// rotates the chain once round, one record a cycle unless the output stalls;
// each matching record is held back one step so that the final one can carry
// last, and the chain ends where it began. One item is worked at a time;
// results leave through a single output register.
module retransmit_send_buffer
   import rsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: seq_number[31:0], send_time[63:32], handle[79:64],
   //        range_start[111:80], range_end[143:112]
   input  logic [143:0] req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: out_handle[15:0], out_seq[47:16], occupancy[54:48], zero fill
   output logic [55:0] rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;       // held records
   logic [CNT_BITS-1:0] walk_ff, walk_in;     // rotation steps done
   logic                found_ff, found_in;   // lookup holds a pending record
   logic                stop_ff, stop_in;     // lookup reached end
   logic [1:0]  act_ff, act_in;
   logic [31:0] seq_ff, seq_in, rs_ff, rs_in, re_ff, re_in;
   logic [31:0] lat_ff;
   logic        late_ff, tsbpd_ff;
   logic        ov_ff, ov_in;
   logic [2:0]  o_st_ff, o_st_in;
   logic [15:0] o_h_ff, o_h_in;
   logic [31:0] o_seq_ff, o_seq_in;
   logic        o_last_ff, o_last_in;
   logic [15:0] pend_h_ff, pend_h_in;
   logic [31:0] pend_seq_ff, pend_seq_in;
   logic [31:0] tail_seq_ff, tail_seq_in;
   logic [31:0] tail_ts_ff, tail_ts_in;

   ring_ctl_type ctl;
   rec_type head_rec;
   logic [31:0] span, diff;

   rsb_ring u_ring (.clock(clock), .ctl(ctl), .head_rec(head_rec));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0; late_ff <= 1'b0; tsbpd_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LATENCY: lat_ff   <= csr_wdata;
            REG_LATE:    late_ff  <= csr_wdata[0];
            REG_TSBPD:   tsbpd_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Folded timestamp span between the oldest and the newest record.
   // The newest record only ever changes on a push, so it is kept aside.
   always_comb begin
      diff = (tail_ts_ff > head_rec.tstamp) ? tail_ts_ff - head_rec.tstamp
                                            : head_rec.tstamp - tail_ts_ff;
      span = (diff > HALF_SPAN) ? ALL32 - diff : diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
      end
      walk_ff <= walk_in; found_ff <= found_in; stop_ff <= stop_in;
      act_ff <= act_in; seq_ff <= seq_in; rs_ff <= rs_in; re_ff <= re_in;
      o_st_ff <= o_st_in; o_h_ff <= o_h_in; o_seq_ff <= o_seq_in;
      o_last_ff <= o_last_in;
      pend_h_ff <= pend_h_in; pend_seq_ff <= pend_seq_in;
      tail_seq_ff <= tail_seq_in; tail_ts_ff <= tail_ts_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;

   // Sequencer
   always_comb begin
      logic        refuse;
      logic        fire;
      logic        hit;
      logic        out_free;
      state_in = state_ff; cnt_in = cnt_ff; walk_in = walk_ff;
      found_in = found_ff; stop_in = stop_ff; act_in = act_ff;
      seq_in = seq_ff; rs_in = rs_ff; re_in = re_ff;
      ov_in = ov_ff; o_st_in = o_st_ff; o_h_in = o_h_ff; o_seq_in = o_seq_ff;
      o_last_in = o_last_ff;
      pend_h_in = pend_h_ff; pend_seq_in = pend_seq_ff;
      tail_seq_in = tail_seq_ff; tail_ts_in = tail_ts_ff;
      ctl = '0;
      ctl.load_rec = '{seq: req_tdata[31:0], tstamp: req_tdata[63:32],
                       hnd: req_tdata[79:64]};
      refuse = 1'b0;
      fire = 1'b0;
      hit = (walk_ff < cnt_ff) && !stop_ff && (head_rec.seq >= rs_ff);
      out_free = !ov_ff || rsp_tready;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !ov_ff) begin
               act_in = req_tuser; seq_in = req_tdata[31:0];
               rs_in = req_tdata[111:80]; re_in = req_tdata[143:112];
               walk_in = '0; found_in = 1'b0; stop_in = 1'b0;
               unique case (req_tuser)
                  ACT_PUSH: begin
                     if (cnt_ff == CNT_BITS'(DEPTH)) begin
                        // Full: rotate so the oldest lands at the tail, overwrite it.
                        ctl.shift = 1'b1;
                        ctl.load  = 1'b1;
                        ctl.load_pos = PTR_BITS'(DEPTH - 1);
                     end else begin
                        ctl.load = 1'b1;
                        ctl.load_pos = PTR_BITS'(cnt_ff);
                        cnt_in = cnt_ff + CNT_BITS'(1);
                     end
                     tail_seq_in = req_tdata[31:0];
                     tail_ts_in  = req_tdata[63:32];
                     state_in = S_LATE;
                  end
                  ACT_DROP:  state_in = S_DROP;
                  ACT_RANGE: state_in = S_RANGE;
                  default:   ;
               endcase
            end
         end
         S_LATE: begin
            // Pop one oldest record a cycle while late drop and TSBPD are on and the span is too wide.
            if (late_ff && tsbpd_ff && cnt_ff != '0 && span > lat_ff) begin
               ctl.shift = 1'b1;
               cnt_in = cnt_ff - CNT_BITS'(1);
            end else begin
               o_st_in = ST_PUSHED; fire = 1'b1;
            end
         end
         S_DROP: begin
            if (walk_ff == '0) begin
               if (cnt_ff == '0) refuse = 1'b1;
               else if (tail_seq_ff > head_rec.seq)
                  refuse = (seq_ff > tail_seq_ff) || (seq_ff < head_rec.seq);
               else
                  refuse = (seq_ff > tail_seq_ff) && (seq_ff < head_rec.seq);
            end
            if (refuse) begin
               o_st_in = ST_REFUSED; fire = 1'b1;
            end else if (walk_ff == cnt_ff) begin
               // Not held: turn the chain back to where it stood.
               if (walk_ff == CNT_BITS'(DEPTH) || walk_ff == '0) begin
                  o_st_in = ST_DROP_OK; fire = 1'b1;
               end else begin
                  ctl.shift = 1'b1;
                  walk_in = walk_ff + CNT_BITS'(1);
                  cnt_in = cnt_ff;
                  act_in = ACT_PUSH;  // marks the restore pass
               end
            end else if (act_ff == ACT_PUSH) begin
               // Restore pass: keep rotating until a full turn.
               if (walk_ff == CNT_BITS'(DEPTH)) begin
                  o_st_in = ST_DROP_OK; fire = 1'b1;
               end else begin
                  ctl.shift = 1'b1;
                  walk_in = walk_ff + CNT_BITS'(1);
               end
            end else if (head_rec.seq == seq_ff) begin
               cnt_in = cnt_ff - walk_ff;
               o_st_in = ST_DROP_OK; fire = 1'b1;
            end else begin
               ctl.shift = 1'b1;
               walk_in = walk_ff + CNT_BITS'(1);
            end
         end
         S_RANGE: begin
            // A matching record waits in the pending register until the next
            // match or the end of the turn shows whether it is the final one.
            if (walk_ff == CNT_BITS'(DEPTH)) begin
               if (!found_ff) begin
                  o_st_in = ST_EMPTY; fire = 1'b1;
               end else if (out_free) begin
                  o_st_in = ST_ENTRY; o_h_in = pend_h_ff; o_seq_in = pend_seq_ff;
                  o_last_in = 1'b1; ov_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (!(hit && found_ff) || out_free) begin
               ctl.shift = 1'b1;
               walk_in = walk_ff + CNT_BITS'(1);
               if (hit) begin
                  if (found_ff) begin
                     o_st_in = ST_ENTRY; o_h_in = pend_h_ff; o_seq_in = pend_seq_ff;
                     o_last_in = 1'b0; ov_in = 1'b1;
                  end
                  found_in = 1'b1;
                  pend_h_in = head_rec.hnd;
                  pend_seq_in = head_rec.seq;
                  if (head_rec.seq == re_ff) stop_in = 1'b1;
               end
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (fire) begin
         o_h_in = '0; o_seq_in = '0; o_last_in = 1'b1; ov_in = 1'b1;
         state_in = S_IDLE;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {1'b0, cnt_ff, o_seq_ff, o_h_ff};
   assign rsp_tuser  = o_st_ff;
   assign rsp_tlast  = o_last_ff;

   // Checks
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(DEPTH)) else $error("held count above depth");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result lost");

endmodule
